@@ rtl/ptd_pkg.sv @@
`default_nettype none
package ptd_pkg;

	// field and datapath widths
	localparam int COORD_W    = 32;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int RF_W       = 208;
	localparam int NREG       = 28;
	localparam int RA_W       = 5;
	localparam int ROOT_W     = 32;
	localparam int BIT_W      = 5;
	localparam int ROOT_SHIFT = 2 * (ROOT_W - 1);
	localparam int NUOP       = 40;
	localparam int PC_W       = 6;

	// tolerance of 0.01 as the rational 1/100
	localparam int TOL_SCALE  = 100;
	localparam int TOL_SPAN   = 101;

	localparam logic [COORD_W-1:0] DIST_MAX = 32'h7fff_ffff;
	localparam logic [COORD_W-1:0] DIST_MIN = 32'h8000_0000;

	typedef logic [RA_W-1:0] raddr_t;

	// scratch register map
	localparam raddr_t R_TX   = 5'd0;
	localparam raddr_t R_TY   = 5'd1;
	localparam raddr_t R_TZ   = 5'd2;
	localparam raddr_t R_E1X  = 5'd3;
	localparam raddr_t R_E1Y  = 5'd4;
	localparam raddr_t R_E1Z  = 5'd5;
	localparam raddr_t R_E2X  = 5'd6;
	localparam raddr_t R_E2Y  = 5'd7;
	localparam raddr_t R_E2Z  = 5'd8;
	localparam raddr_t R_K100 = 5'd9;
	localparam raddr_t R_K101 = 5'd10;
	localparam raddr_t R_AA   = 5'd11;
	localparam raddr_t R_AB   = 5'd12;
	localparam raddr_t R_BB   = 5'd13;
	localparam raddr_t R_TA   = 5'd14;
	localparam raddr_t R_TB   = 5'd15;
	localparam raddr_t R_DET  = 5'd16;
	localparam raddr_t R_N1   = 5'd17;
	localparam raddr_t R_N2   = 5'd18;
	localparam raddr_t R_H1   = 5'd19;
	localparam raddr_t R_H2   = 5'd20;
	localparam raddr_t R_KD   = 5'd21;
	localparam raddr_t R_TMP  = 5'd22;
	localparam raddr_t R_C0   = 5'd23;
	localparam raddr_t R_C1   = 5'd24;
	localparam raddr_t R_C2   = 5'd25;
	localparam raddr_t R_TC   = 5'd26;
	localparam raddr_t R_PP   = 5'd27;

	typedef enum logic [2:0] {
		OP_MUL = 3'd0,
		OP_MAC = 3'd1,
		OP_MSC = 3'd2,
		OP_ADD = 3'd3,
		OP_SUB = 3'd4
	} op_t;

	typedef struct packed {
		op_t    op;
		raddr_t dst;
		raddr_t a;
		raddr_t b;
		logic   chk_neg;
		logic   chk_zero;
		logic   save_sign;
	} uop_t;

	typedef struct packed {
		logic                      command;
		logic signed [COORD_W-1:0] v0_x;
		logic signed [COORD_W-1:0] v0_y;
		logic signed [COORD_W-1:0] v0_z;
		logic signed [COORD_W-1:0] v1_x;
		logic signed [COORD_W-1:0] v1_y;
		logic signed [COORD_W-1:0] v1_z;
		logic signed [COORD_W-1:0] v2_x;
		logic signed [COORD_W-1:0] v2_y;
		logic signed [COORD_W-1:0] v2_z;
		logic                      last_triangle;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] min_distance;
		logic                      found;
		logic                      near;
	} res_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_cmd_t;

	typedef struct packed {
		logic            done;
		logic [RF_W-1:0] data;
	} alu_res_t;

	function automatic uop_t mk(input op_t op, input raddr_t dst, input raddr_t a,
		input raddr_t b, input logic cn, input logic cz, input logic ss);
		uop_t u;
		u.op        = op;
		u.dst       = dst;
		u.a         = a;
		u.b         = b;
		u.chk_neg   = cn;
		u.chk_zero  = cz;
		u.save_sign = ss;
		return u;
	endfunction

	// per-triangle program: gram terms, metric, tolerance tests, triple product
	function automatic uop_t uop(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(OP_MUL, R_AA, R_E1X, R_E1X, 1'b0, 1'b0, 1'b0);
			6'd1:  u = mk(OP_MAC, R_AA, R_E1Y, R_E1Y, 1'b0, 1'b0, 1'b0);
			6'd2:  u = mk(OP_MAC, R_AA, R_E1Z, R_E1Z, 1'b0, 1'b0, 1'b0);
			6'd3:  u = mk(OP_MUL, R_AB, R_E1X, R_E2X, 1'b0, 1'b0, 1'b0);
			6'd4:  u = mk(OP_MAC, R_AB, R_E1Y, R_E2Y, 1'b0, 1'b0, 1'b0);
			6'd5:  u = mk(OP_MAC, R_AB, R_E1Z, R_E2Z, 1'b0, 1'b0, 1'b0);
			6'd6:  u = mk(OP_MUL, R_BB, R_E2X, R_E2X, 1'b0, 1'b0, 1'b0);
			6'd7:  u = mk(OP_MAC, R_BB, R_E2Y, R_E2Y, 1'b0, 1'b0, 1'b0);
			6'd8:  u = mk(OP_MAC, R_BB, R_E2Z, R_E2Z, 1'b0, 1'b0, 1'b0);
			6'd9:  u = mk(OP_MUL, R_TA, R_E1X, R_TX, 1'b0, 1'b0, 1'b0);
			6'd10: u = mk(OP_MAC, R_TA, R_E1Y, R_TY, 1'b0, 1'b0, 1'b0);
			6'd11: u = mk(OP_MAC, R_TA, R_E1Z, R_TZ, 1'b0, 1'b0, 1'b0);
			6'd12: u = mk(OP_MUL, R_TB, R_E2X, R_TX, 1'b0, 1'b0, 1'b0);
			6'd13: u = mk(OP_MAC, R_TB, R_E2Y, R_TY, 1'b0, 1'b0, 1'b0);
			6'd14: u = mk(OP_MAC, R_TB, R_E2Z, R_TZ, 1'b0, 1'b0, 1'b0);
			6'd15: u = mk(OP_MUL, R_DET, R_AA, R_BB, 1'b0, 1'b0, 1'b0);
			6'd16: u = mk(OP_MSC, R_DET, R_AB, R_AB, 1'b0, 1'b1, 1'b0);
			6'd17: u = mk(OP_MUL, R_N1, R_BB, R_TA, 1'b0, 1'b0, 1'b0);
			6'd18: u = mk(OP_MSC, R_N1, R_AB, R_TB, 1'b0, 1'b0, 1'b0);
			6'd19: u = mk(OP_MUL, R_N2, R_AA, R_TB, 1'b0, 1'b0, 1'b0);
			6'd20: u = mk(OP_MSC, R_N2, R_AB, R_TA, 1'b0, 1'b0, 1'b0);
			6'd21: u = mk(OP_MUL, R_H1, R_N1, R_K100, 1'b0, 1'b0, 1'b0);
			6'd22: u = mk(OP_MUL, R_H2, R_N2, R_K100, 1'b0, 1'b0, 1'b0);
			6'd23: u = mk(OP_MUL, R_KD, R_DET, R_K101, 1'b0, 1'b0, 1'b0);
			6'd24: u = mk(OP_ADD, R_TMP, R_H1, R_DET, 1'b1, 1'b0, 1'b0);
			6'd25: u = mk(OP_SUB, R_TMP, R_KD, R_H1, 1'b1, 1'b0, 1'b0);
			6'd26: u = mk(OP_ADD, R_TMP, R_H2, R_DET, 1'b1, 1'b0, 1'b0);
			6'd27: u = mk(OP_SUB, R_TMP, R_KD, R_H2, 1'b1, 1'b0, 1'b0);
			6'd28: u = mk(OP_SUB, R_TMP, R_KD, R_H1, 1'b0, 1'b0, 1'b0);
			6'd29: u = mk(OP_SUB, R_TMP, R_TMP, R_H2, 1'b1, 1'b0, 1'b0);
			6'd30: u = mk(OP_MUL, R_C0, R_E1Y, R_E2Z, 1'b0, 1'b0, 1'b0);
			6'd31: u = mk(OP_MSC, R_C0, R_E1Z, R_E2Y, 1'b0, 1'b0, 1'b0);
			6'd32: u = mk(OP_MUL, R_C1, R_E1Z, R_E2X, 1'b0, 1'b0, 1'b0);
			6'd33: u = mk(OP_MSC, R_C1, R_E1X, R_E2Z, 1'b0, 1'b0, 1'b0);
			6'd34: u = mk(OP_MUL, R_C2, R_E1X, R_E2Y, 1'b0, 1'b0, 1'b0);
			6'd35: u = mk(OP_MSC, R_C2, R_E1Y, R_E2X, 1'b0, 1'b0, 1'b0);
			6'd36: u = mk(OP_MUL, R_TC, R_C0, R_TX, 1'b0, 1'b0, 1'b0);
			6'd37: u = mk(OP_MAC, R_TC, R_C1, R_TY, 1'b0, 1'b0, 1'b0);
			6'd38: u = mk(OP_MAC, R_TC, R_C2, R_TZ, 1'b0, 1'b0, 1'b1);
			6'd39: u = mk(OP_MUL, R_PP, R_TC, R_TC, 1'b0, 1'b0, 1'b0);
			default: u = mk(OP_MUL, R_TMP, R_TX, R_TX, 1'b0, 1'b0, 1'b0);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ptd_regfile.sv @@
`default_nettype none
module ptd_regfile (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire ptd_pkg::raddr_t           waddr,
	input  wire logic [ptd_pkg::RF_W-1:0]  wdata,
	input  wire ptd_pkg::raddr_t           raddr_a,
	input  wire ptd_pkg::raddr_t           raddr_b,
	output logic      [ptd_pkg::RF_W-1:0]  rdata_a,
	output logic      [ptd_pkg::RF_W-1:0]  rdata_b
);

	logic [ptd_pkg::RF_W-1:0] mem [ptd_pkg::NREG];
	logic [ptd_pkg::RF_W-1:0] rdata_a_q;
	logic [ptd_pkg::RF_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule
`default_nettype wire

@@ rtl/ptd_alu.sv @@
`default_nettype none
module ptd_alu (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ptd_pkg::alu_cmd_t         cmd,
	input  wire logic [ptd_pkg::RF_W-1:0]  rd_a,
	input  wire logic [ptd_pkg::RF_W-1:0]  rd_b,
	output ptd_pkg::alu_res_t              res
);

	localparam int W = ptd_pkg::RF_W;

	typedef enum logic [2:0] {
		AL_IDLE = 3'b001,
		AL_MUL  = 3'b010,
		AL_FIN  = 3'b100
	} al_state_t;

	al_state_t      state_q;
	logic           first_q;
	logic [W-1:0]   mcand_q;
	logic [W-1:0]   mplier_q;
	logic [W-1:0]   acc_q;
	logic [W-1:0]   base_q;
	logic           neg_q;
	logic           use_base_q;
	logic           is_add;
	logic [W-1:0]   add_x;
	logic [W-1:0]   add_y;
	logic           add_sub;
	logic [W-1:0]   add_sum;

	function automatic logic [W-1:0] mag(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	assign is_add = (cmd.op == ptd_pkg::OP_ADD) || (cmd.op == ptd_pkg::OP_SUB);

	// shared adder: add/sub of operands, or signed fold of product into base
	always_comb begin
		add_x   = base_q;
		add_y   = acc_q;
		add_sub = neg_q;
		if (state_q == AL_IDLE) begin
			add_x   = rd_a;
			add_y   = rd_b;
			add_sub = (cmd.op == ptd_pkg::OP_SUB);
		end
	end

	assign add_sum  = add_x + (add_y ^ {W{add_sub}}) + {{(W-1){1'b0}}, add_sub};
	assign res.data = add_sum;
	assign res.done = (state_q == AL_FIN) || (state_q == AL_IDLE && cmd.start && is_add);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AL_IDLE;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				AL_IDLE: begin
					if (cmd.start && !is_add) begin
						state_q <= AL_MUL;
						first_q <= 1'b1;
					end
				end
				AL_MUL: begin
					first_q <= 1'b0;
					if (mplier_q == '0) begin
						state_q <= AL_FIN;
					end
				end
				AL_FIN: state_q <= AL_IDLE;
				default: state_q <= AL_IDLE;
			endcase
		end
	end

	// shift-add over magnitudes, one multiplier bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == AL_IDLE && cmd.start) begin
			mcand_q    <= mag(rd_a);
			mplier_q   <= mag(rd_b);
			neg_q      <= rd_a[W-1] ^ rd_b[W-1] ^ (cmd.op == ptd_pkg::OP_MSC);
			use_base_q <= (cmd.op != ptd_pkg::OP_MUL);
			acc_q      <= '0;
		end else if (state_q == AL_MUL) begin
			if (first_q) begin
				base_q <= use_base_q ? rd_a : '0;
			end
			if (mplier_q != '0) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/ptd_isqrt.sv @@
`default_nettype none
module ptd_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [ptd_pkg::RF_W-1:0]    p,
	input  wire logic [ptd_pkg::RF_W-1:0]    d,
	output logic                             done,
	output logic      [ptd_pkg::ROOT_W-1:0]  root
);

	localparam int W = ptd_pkg::RF_W;

	typedef enum logic [2:0] {
		RT_IDLE = 3'b001,
		RT_SUM  = 3'b010,
		RT_TRY  = 3'b100
	} rt_state_t;

	rt_state_t                     state_q;
	logic [ptd_pkg::BIT_W-1:0]     bit_q;
	logic                          done_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  q_q;
	logic [W-1:0]                  dq_q;
	logic [W-1:0]                  x_q;
	logic [ptd_pkg::ROOT_W-1:0]    root_q;
	logic [W-1:0]                  y;
	logic                          ok;

	// rem = p - m*m*d, q = m*d << (b+1), dq = d << 2b
	assign y  = rem_q - x_q;
	assign ok = !y[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RT_IDLE;
			bit_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				RT_IDLE: begin
					if (start) begin
						state_q <= RT_SUM;
						bit_q   <= ptd_pkg::BIT_W'(ptd_pkg::ROOT_W - 1);
					end
				end
				RT_SUM: state_q <= RT_TRY;
				RT_TRY: begin
					if (bit_q == '0) begin
						state_q <= RT_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= RT_SUM;
						bit_q   <= bit_q - 1'b1;
					end
				end
				default: state_q <= RT_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == RT_IDLE && start) begin
			rem_q  <= p;
			q_q    <= '0;
			dq_q   <= d << ptd_pkg::ROOT_SHIFT;
			root_q <= '0;
		end else if (state_q == RT_SUM) begin
			x_q <= q_q + dq_q;
		end else if (state_q == RT_TRY) begin
			if (ok) begin
				rem_q         <= y;
				root_q[bit_q] <= 1'b1;
			end
			q_q  <= (q_q >> 1) + (ok ? dq_q : '0);
			dq_q <= dq_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

@@ rtl/point_to_triangle_min_distance.sv @@
`default_nettype none
// point to triangle minimum signed distance. a request with command 0 loads the query
// point and clears the running minimum. a request with command 1 carries a triangle; the
// block works on it alone, so req_stall stays high until it is done. a triangle first
// loads 11 scratch values, then runs 40 steps of a shared serial multiply-add unit (each
// multiply takes one bit of the second operand per cycle and stops once its remaining
// bits are zero), then the root (read, start, a sum and a try step for each of the 32
// root bits, and the done strobe) and the update. small coordinates need less work, and
// a triangle rejected early (flat triangle or projection outside the widened edges) less
// still. on a triangle marked last a result is loaded into the output register; the next
// request is taken while that result waits. all arithmetic is exact on 208-bit scratch
// registers, so the fixed point scale drops out
module point_to_triangle_min_distance (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire ptd_pkg::req_t                req,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output ptd_pkg::res_t                     res,
	input  wire logic                         cfg_we,
	input  wire logic [ptd_pkg::COORD_W-1:0]  cfg_wdata
);

	localparam int W  = ptd_pkg::RF_W;
	localparam int CW = ptd_pkg::COORD_W;
	localparam int DW = ptd_pkg::DIFF_W;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_LOAD   = 10'b00_0000_0010,
		ST_ISSUE  = 10'b00_0000_0100,
		ST_START  = 10'b00_0000_1000,
		ST_WAIT   = 10'b00_0001_0000,
		ST_RRD    = 10'b00_0010_0000,
		ST_RSTART = 10'b00_0100_0000,
		ST_RWAIT  = 10'b00_1000_0000,
		ST_UPD    = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} st_t;

	st_t                          state_q;
	logic [ptd_pkg::PC_W-1:0]     pc_q;
	ptd_pkg::raddr_t              ld_q;
	ptd_pkg::req_t                req_q;
	logic [CW-1:0]                qp_x_q;
	logic [CW-1:0]                qp_y_q;
	logic [CW-1:0]                qp_z_q;
	logic [CW-1:0]                near_limit_q;
	logic [CW-1:0]                best_q;
	logic                         any_q;
	logic                         hit_q;
	logic                         tc_neg_q;
	logic [ptd_pkg::ROOT_W-1:0]   root_q;
	logic                         res_valid_q;
	ptd_pkg::res_t                res_q;

	ptd_pkg::uop_t                u;
	logic                         accept;
	logic                         rf_we;
	ptd_pkg::raddr_t              rf_waddr;
	logic [W-1:0]                 rf_wdata;
	ptd_pkg::raddr_t              raddr_a;
	ptd_pkg::raddr_t              raddr_b;
	logic [W-1:0]                 rd_a;
	logic [W-1:0]                 rd_b;
	logic [DW-1:0]                ld_val;
	ptd_pkg::alu_cmd_t            alu_cmd;
	ptd_pkg::alu_res_t            alu_res;
	logic                         reject;
	logic                         root_done;
	logic [ptd_pkg::ROOT_W-1:0]   root_w;
	logic [CW-1:0]                tri_dist;
	logic [CW-1:0]                dist_mag;
	logic [CW-1:0]                best_mag;
	logic                         take_dist;
	logic                         out_free;

	function automatic logic [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return {a[CW-1], a} - {b[CW-1], b};
	endfunction

	function automatic logic [CW-1:0] mag32(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + 1'b1) : v;
	endfunction

	assign u         = ptd_pkg::uop(pc_q);
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// operand load: offsets from the first vertex, then the tolerance constants
	always_comb begin
		case (ld_q)
			ptd_pkg::R_TX:   ld_val = diff(qp_x_q, req_q.v0_x);
			ptd_pkg::R_TY:   ld_val = diff(qp_y_q, req_q.v0_y);
			ptd_pkg::R_TZ:   ld_val = diff(qp_z_q, req_q.v0_z);
			ptd_pkg::R_E1X:  ld_val = diff(req_q.v1_x, req_q.v0_x);
			ptd_pkg::R_E1Y:  ld_val = diff(req_q.v1_y, req_q.v0_y);
			ptd_pkg::R_E1Z:  ld_val = diff(req_q.v1_z, req_q.v0_z);
			ptd_pkg::R_E2X:  ld_val = diff(req_q.v2_x, req_q.v0_x);
			ptd_pkg::R_E2Y:  ld_val = diff(req_q.v2_y, req_q.v0_y);
			ptd_pkg::R_E2Z:  ld_val = diff(req_q.v2_z, req_q.v0_z);
			ptd_pkg::R_K100: ld_val = DW'(ptd_pkg::TOL_SCALE);
			ptd_pkg::R_K101: ld_val = DW'(ptd_pkg::TOL_SPAN);
			default:         ld_val = '0;
		endcase
	end

	// scratch write port: loader first, then the arithmetic unit
	assign rf_we    = (state_q == ST_LOAD) || alu_res.done;
	assign rf_waddr = (state_q == ST_LOAD) ? ld_q : u.dst;
	assign rf_wdata = (state_q == ST_LOAD) ? {{(W-DW){ld_val[DW-1]}}, ld_val} : alu_res.data;

	// read ports: operands on issue, accumulate base while starting, root inputs
	always_comb begin
		raddr_a = u.dst;
		raddr_b = u.b;
		case (state_q)
			ST_ISSUE: raddr_a = u.a;
			ST_RRD: begin
				raddr_a = ptd_pkg::R_PP;
				raddr_b = ptd_pkg::R_DET;
			end
			default: raddr_a = u.dst;
		endcase
	end

	assign alu_cmd.start = (state_q == ST_START);
	assign alu_cmd.op    = u.op;

	assign reject = (u.chk_neg && alu_res.data[W-1]) || (u.chk_zero && alu_res.data == '0);

	ptd_regfile u_rf (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (rf_waddr),
		.wdata   (rf_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	ptd_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.rd_a   (rd_a),
		.rd_b   (rd_b),
		.res    (alu_res)
	);

	ptd_isqrt u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_RSTART),
		.p      (rd_a),
		.d      (rd_b),
		.done   (root_done),
		.root   (root_w)
	);

	// signed distance from the root, saturated on each side
	always_comb begin
		if (tc_neg_q) begin
			tri_dist = (root_q > ptd_pkg::DIST_MIN) ? ptd_pkg::DIST_MIN : root_q;
			tri_dist = ~tri_dist + 1'b1;
		end else begin
			tri_dist = (root_q > ptd_pkg::DIST_MAX) ? ptd_pkg::DIST_MAX : root_q;
		end
	end

	assign dist_mag  = mag32(tri_dist);
	assign best_mag  = mag32(best_q);
	// an equal magnitude keeps the earlier distance
	assign take_dist = hit_q && (!any_q || dist_mag < best_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= '0;
			ld_q         <= ptd_pkg::R_TX;
			qp_x_q       <= '0;
			qp_y_q       <= '0;
			qp_z_q       <= '0;
			near_limit_q <= '0;
			best_q       <= ptd_pkg::DIST_MAX;
			any_q        <= 1'b0;
			hit_q        <= 1'b0;
			tc_neg_q     <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				near_limit_q <= cfg_wdata;
			end
			// output register: loaded from emit, cleared once taken
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.command) begin
							state_q <= ST_LOAD;
							ld_q    <= ptd_pkg::R_TX;
						end else begin
							qp_x_q <= req.v0_x;
							qp_y_q <= req.v0_y;
							qp_z_q <= req.v0_z;
							best_q <= ptd_pkg::DIST_MAX;
							any_q  <= 1'b0;
						end
					end
				end
				ST_LOAD: begin
					if (ld_q == ptd_pkg::R_K101) begin
						state_q <= ST_ISSUE;
						pc_q    <= '0;
					end else begin
						ld_q <= ld_q + 1'b1;
					end
				end
				ST_ISSUE: state_q <= ST_START;
				ST_START, ST_WAIT: begin
					if (alu_res.done) begin
						if (u.save_sign) begin
							tc_neg_q <= alu_res.data[W-1];
						end
						if (reject) begin
							hit_q   <= 1'b0;
							state_q <= ST_UPD;
						end else if (pc_q == ptd_pkg::PC_W'(ptd_pkg::NUOP - 1)) begin
							state_q <= ST_RRD;
						end else begin
							pc_q    <= pc_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_RRD:    state_q <= ST_RSTART;
				ST_RSTART: state_q <= ST_RWAIT;
				ST_RWAIT: begin
					if (root_done) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (take_dist) begin
						best_q <= tri_dist;
					end
					if (hit_q) begin
						any_q <= 1'b1;
					end
					state_q <= req_q.last_triangle ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_RWAIT && root_done) begin
			root_q <= root_w;
		end
		if (state_q == ST_EMIT && out_free) begin
			res_q.min_distance <= best_q;
			res_q.found        <= any_q;
			res_q.near         <= any_q && ($signed(best_q) <= $signed(near_limit_q));
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_alu_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_res.done |-> (state_q == ST_START || state_q == ST_WAIT))
		else $error("arithmetic unit finished outside a program step");

	a_root_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_RWAIT)
		else $error("root unit finished while not awaited");

	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> req_q.last_triangle)
		else $error("result raised for a triangle not marked last");

	a_none_max: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> (res.min_distance == ptd_pkg::DIST_MAX && !res.near))
		else $error("empty result without saturated distance");

	a_load_then_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && ld_q == ptd_pkg::R_K101) |=> (state_q == ST_ISSUE && pc_q == '0))
		else $error("program did not start after operand load");
`endif

endmodule
`default_nettype wire
